/* design/crls_pkg.sv */
// ----------------------------------------------------------------------------
// crls_pkg: shared constants and types for the color ramp sampler
// widths, pipeline control struct, divider stage count
// ----------------------------------------------------------------------------
package crls_pkg;

    localparam int RAMP_DEPTH = 256;
    localparam int LIFE_BITS  = 16;
    localparam int FRAC_BITS  = 8;
    localparam int IDX_BITS   = $clog2(RAMP_DEPTH);
    localparam int WID_BITS   = 9;
    // dividend = width * elapsed << frac
    localparam int NUM_BITS   = WID_BITS + LIFE_BITS + FRAC_BITS;
    // quotient is at most width << frac
    localparam int Q_BITS     = WID_BITS + FRAC_BITS;
    localparam int DIV_STAGES = Q_BITS;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // per-item control carried beside the divider
    // ramp writes ride along so they reach the ramp in item order
    typedef struct packed {
        logic                valid;
        logic                zero_total;
        logic [WID_BITS-1:0] width;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_idx;
        logic [31:0]         wr_data;
    } t_ctl;

endpackage

/* design/crls_div.sv */
// ----------------------------------------------------------------------------
// crls_div: pipelined restoring divider
// one quotient bit per stage, control travels alongside
// ----------------------------------------------------------------------------
module crls_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crls_pkg::t_ctl                i_ctl,
    input  logic [crls_pkg::NUM_BITS-1:0] i_num,
    input  logic [crls_pkg::LIFE_BITS-1:0] i_den,
    output crls_pkg::t_ctl                o_ctl,
    output logic [crls_pkg::Q_BITS-1:0]   o_quo
);
    import crls_pkg::*;

    localparam int R_BITS = LIFE_BITS + 1;

    t_ctl                 r_ctl [DIV_STAGES+1];
    logic [NUM_BITS-1:0]  r_num [DIV_STAGES+1];
    logic [LIFE_BITS-1:0] r_den [DIV_STAGES+1];
    logic [R_BITS-1:0]    r_rem [DIV_STAGES+1];
    logic [Q_BITS-1:0]    r_quo [DIV_STAGES+1];

    always_comb begin
        r_ctl[0] = i_ctl;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_rem[0] = '0;
        r_quo[0] = '0;
    end

    // remainder before quotient bits: top bits of dividend above Q_BITS
    // are below den because q fits in Q_BITS, so stage 0 preloads them
    localparam int HI_BITS = NUM_BITS - Q_BITS;

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            logic [R_BITS-1:0] n_rem;
            logic [R_BITS-1:0] n_try;
            logic [R_BITS-1:0] n_base;
            always_comb begin
                if (s == 0) begin
                    n_base = R_BITS'(r_num[s][NUM_BITS-1 -: HI_BITS]);
                end else begin
                    n_base = r_rem[s];
                end
                n_rem = {n_base[R_BITS-2:0], r_num[s][Q_BITS-1-s]};
                n_try = n_rem - {1'b0, r_den[s]};
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[s+1].valid <= 1'b0;
                    r_ctl[s+1].wr_en <= 1'b0;
                end else begin
                    r_ctl[s+1].valid <= r_ctl[s].valid;
                    r_ctl[s+1].wr_en <= r_ctl[s].wr_en;
                end
                r_ctl[s+1].zero_total <= r_ctl[s].zero_total;
                r_ctl[s+1].width      <= r_ctl[s].width;
                r_ctl[s+1].wr_idx     <= r_ctl[s].wr_idx;
                r_ctl[s+1].wr_data    <= r_ctl[s].wr_data;
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                if (n_rem >= {1'b0, r_den[s]}) begin
                    r_rem[s+1] <= n_try;
                    r_quo[s+1] <= {r_quo[s][Q_BITS-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_rem;
                    r_quo[s+1] <= {r_quo[s][Q_BITS-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_ctl = r_ctl[DIV_STAGES];
    assign o_quo = r_quo[DIV_STAGES];

endmodule

/* design/crls_blend.sv */
// ----------------------------------------------------------------------------
// crls_blend: ramp fetch and channel interpolation
// registered dual reads of the ramp, then a registered multiply per lane
// ----------------------------------------------------------------------------
module crls_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crls_pkg::t_ctl                i_ctl,
    input  logic [crls_pkg::Q_BITS-1:0]   i_quo,
    output logic                          o_valid,
    output logic [31:0]                   o_color
);
    import crls_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [31:0] r_mem [RAMP_DEPTH];

    // stage a: choose indexes and fraction
    logic [Q_BITS-FRAC_BITS-1:0] n_qidx;
    logic [WID_BITS-1:0]         n_last;
    logic                        n_end;
    logic [IDX_BITS-1:0]         n_ia;
    logic [IDX_BITS-1:0]         n_ib;
    logic [FRAC_BITS-1:0]        n_f;

    always_comb begin
        n_qidx = i_quo[Q_BITS-1:FRAC_BITS];
        n_last = i_ctl.width - WID_BITS'(1);
        n_end  = i_ctl.zero_total || (n_qidx >= n_last);
        if (i_ctl.zero_total) begin
            n_ia = '0;
        end else if (n_end) begin
            n_ia = n_last[IDX_BITS-1:0];
        end else begin
            n_ia = n_qidx[IDX_BITS-1:0];
        end
        // no neighbor past the end: read the same entry twice
        n_ib = n_end ? n_ia : n_ia + IDX_BITS'(1);
        n_f  = n_end ? '0 : i_quo[FRAC_BITS-1:0];
    end

    // ramp memory: one write port, two registered read ports
    logic [31:0]          r_a;
    logic [31:0]          r_b;
    logic [FRAC_BITS-1:0] r_f;
    logic                 r_v1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_idx] <= i_ctl.wr_data;
        end
        r_a <= r_mem[n_ia];
        r_b <= r_mem[n_ib];
        r_f <= n_f;
    end

    // per-lane products
    logic [8+FRAC_BITS:0] r_pa [4];
    logic [8+FRAC_BITS:0] r_pb [4];
    logic                 r_v2;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_pa[c] <= (9+FRAC_BITS)'(r_a[8*c +: 8] * (ONE - {1'b0, r_f}));
            r_pb[c] <= (9+FRAC_BITS)'(r_b[8*c +: 8] * r_f);
        end
    end

    // sum and truncate
    logic [31:0] r_color;
    logic        r_v3;
    logic [9+FRAC_BITS:0] n_sum [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sum[c] = {1'b0, r_pa[c]} + {1'b0, r_pb[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_color[8*c +: 8] <= n_sum[c][FRAC_BITS +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_color = r_color;

    // results follow a valid item by a fixed latency
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid |-> ##3 o_valid)
        else $error("blend lost an item");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.valid |-> ##3 !o_valid)
        else $error("blend invented an item");
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.valid && i_ctl.zero_total) |=> (r_f == '0))
        else $error("zero total must not interpolate");

endmodule

/* design/color_ramp_lerp_sampler.sv */
// ----------------------------------------------------------------------------
// color_ramp_lerp_sampler: ARGB color ramp sampling by particle life
// divider pipeline followed by ramp fetch and channel blend
// ----------------------------------------------------------------------------
// One item is taken every cycle (busy stays low). A write item gives no
// result; it travels down the pipeline beside the sample items and reaches
// the ramp where samples read it, so each sample sees exactly the writes
// taken before it. A sample item gives its color on o_color_out with o_strobe
// high for one cycle once it has passed 21 register stages, the first
// loaded by the edge that takes it: one input register, 17 divider stages
// (one quotient bit each) and three stages of ramp read and blend. Results
// leave in item order and cannot be held off.
module color_ramp_lerp_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_operation,
    input  logic [7:0]  i_entry_index,
    input  logic [31:0] i_entry_color,
    input  logic [15:0] i_life_total,
    input  logic [15:0] i_life_remaining,
    output logic        o_strobe,
    output logic [31:0] o_color_out
);
    import crls_pkg::*;

    logic [WID_BITS-1:0] r_width;

    // ramp width register; the value used is saturated to the usable range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WID_BITS'(RAMP_DEPTH);
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    logic [WID_BITS-1:0] n_w;
    always_comb begin
        if (r_width == '0) begin
            n_w = WID_BITS'(1);
        end else if (r_width > WID_BITS'(RAMP_DEPTH)) begin
            n_w = WID_BITS'(RAMP_DEPTH);
        end else begin
            n_w = r_width;
        end
    end

    assign busy = 1'b0;

    // input stage: elapsed and control
    logic                 n_acc;
    logic [LIFE_BITS-1:0] n_el;
    t_ctl                 r_ctl;
    logic [LIFE_BITS-1:0] r_el;
    logic [LIFE_BITS-1:0] r_tot;

    always_comb begin
        n_acc = start && !busy;
        n_el  = (i_life_remaining > i_life_total) ? '0 : i_life_total - i_life_remaining;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
            r_ctl.wr_en <= 1'b0;
        end else begin
            r_ctl.valid <= n_acc && (i_operation == OP_SAMPLE);
            r_ctl.wr_en <= n_acc && (i_operation == OP_WRITE);
        end
        r_ctl.zero_total <= (i_life_total == '0);
        r_ctl.width      <= n_w;
        r_ctl.wr_idx     <= i_entry_index;
        r_ctl.wr_data    <= i_entry_color;
        r_el  <= n_el;
        r_tot <= i_life_total;
    end

    // dividend: width * elapsed, scaled by fraction
    logic [NUM_BITS-1:0] n_num;
    always_comb begin
        n_num = NUM_BITS'(r_ctl.width * r_el) << FRAC_BITS;
    end

    t_ctl              d_ctl;
    logic [Q_BITS-1:0] d_quo;

    crls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_num   (n_num),
        .i_den   (r_tot),
        .o_ctl   (d_ctl),
        .o_quo   (d_quo)
    );

    crls_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (d_ctl),
        .i_quo     (d_quo),
        .o_valid   (o_strobe),
        .o_color   (o_color_out)
    );

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy must stay low");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_operation == OP_WRITE) |=> !r_ctl.valid)
        else $error("write item entered the sample pipeline");
    a_wid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid |-> (r_ctl.width != '0 && r_ctl.width <= WID_BITS'(RAMP_DEPTH)))
        else $error("ramp width out of range");

endmodule
